// ===== rtl/i2cm_pkg.sv =====
// Shared types and codes for the bit-level I2C master core.
package i2cm_pkg;

   localparam int UNIT_W     = 16;
   localparam int POLL_W     = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [UNIT_W-1:0] UNIT_TICKS_RST     = 16'd128;
   localparam logic [POLL_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_TICKS     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_POLL_LIMIT = 4'd1;

   // Command codes carried by an item
   localparam logic [2:0] MODE_START    = 3'd0;
   localparam logic [2:0] MODE_STOP     = 3'd1;
   localparam logic [2:0] MODE_WRITE    = 3'd2;
   localparam logic [2:0] MODE_READ     = 3'd3;
   localparam logic [2:0] MODE_WAIT_ACK = 3'd4;

   typedef struct packed {
      logic [UNIT_W-1:0] unit_ticks;
      logic [POLL_W-1:0] ack_poll_limit;
   } cfg_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] write_data;
      logic       send_ack;
      logic       sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_is_output;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_timeout;
   } result_type;

endpackage

// ===== rtl/i2cm_csr.sv =====
// Configuration registers of the I2C master: unit length and ack poll limit.
module i2cm_csr #(
   parameter logic [i2cm_pkg::UNIT_W-1:0] UnitTicksRst    = i2cm_pkg::UNIT_TICKS_RST,
   parameter logic [i2cm_pkg::POLL_W-1:0] AckPollLimitRst = i2cm_pkg::ACK_POLL_LIMIT_RST
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [i2cm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]   csr_data,
   output i2cm_pkg::cfg_type                 cfg
);

   logic [i2cm_pkg::UNIT_W-1:0] unit_ticks_ff, unit_ticks_in;
   logic [i2cm_pkg::POLL_W-1:0] poll_limit_ff, poll_limit_in;

   assign csr_ready = 1'b1;

   always_comb begin
      unit_ticks_in = unit_ticks_ff;
      poll_limit_in = poll_limit_ff;
      if (csr_valid) begin
         // drop writes to indexes beyond the register list
         if (csr_index == i2cm_pkg::CSR_UNIT_TICKS) begin
            unit_ticks_in = csr_data[i2cm_pkg::UNIT_W-1:0];
         end else if (csr_index == i2cm_pkg::CSR_ACK_POLL_LIMIT) begin
            poll_limit_in = csr_data[i2cm_pkg::POLL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UnitTicksRst;
         poll_limit_ff <= AckPollLimitRst;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
         poll_limit_ff <= poll_limit_in;
      end
   end

   assign cfg.unit_ticks     = unit_ticks_ff;
   assign cfg.ack_poll_limit = poll_limit_ff;

endmodule

// ===== rtl/i2cm_engine.sv =====
// Bus waveform sequencer: one tick per step, state registers double as result.
module i2cm_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  i2cm_pkg::item_type    item,
   input  i2cm_pkg::cfg_type     cfg,
   output i2cm_pkg::result_type  result
);

   typedef enum logic [4:0] {
      PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_W1, PH_W2A, PH_W2B, PH_W3,
      PH_R1, PH_R2A, PH_R2B, PH_R3, PH_A1, PH_A2, PH_K1, PH_KP, PH_KL,
      PH_T1, PH_T2
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [i2cm_pkg::UNIT_W-1:0] unit_count_ff, unit_count_in;
   logic [2:0]                  bit_index_ff, bit_index_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [i2cm_pkg::POLL_W-1:0] poll_count_ff, poll_count_in;
   logic                        ack_flag_ff, ack_flag_in;
   logic                        scl_ff, scl_in;
   logic                        sda_ff, sda_in;
   logic                        sda_dir_ff, sda_dir_in;
   logic [7:0]                  rd_byte_ff, rd_byte_in;
   logic                        ack_choice_ff, ack_choice_in;
   logic                        done_ff, done_in;
   logic [i2cm_pkg::UNIT_W:0]   unit_next;
   logic                        finish;

   always_comb begin
      phase_in      = phase_ff;
      unit_count_in = unit_count_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      poll_count_in = poll_count_ff;
      ack_flag_in   = ack_flag_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      sda_dir_in    = sda_dir_ff;
      rd_byte_in    = rd_byte_ff;
      ack_choice_in = ack_choice_ff;
      done_in       = 1'b0;
      finish        = 1'b0;
      unit_next     = {1'b0, unit_count_ff} + 1'b1;

      if (phase_ff == PH_IDLE) begin
         if (item.cmd_valid) begin
            unit_count_in = '0;
            case (item.mode)
               i2cm_pkg::MODE_START: begin
                  sda_dir_in = 1'b1; scl_in = 1'b1; sda_in = 1'b1; phase_in = PH_S1;
               end
               i2cm_pkg::MODE_STOP: begin
                  sda_dir_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0; phase_in = PH_P1;
               end
               i2cm_pkg::MODE_WRITE: begin
                  sda_dir_in   = 1'b1;
                  scl_in       = 1'b0;
                  shift_in     = item.write_data;
                  bit_index_in = '0;
                  sda_in       = item.write_data[7];
                  phase_in     = PH_W1;
               end
               i2cm_pkg::MODE_READ: begin
                  sda_dir_in    = 1'b0;
                  scl_in        = 1'b0;
                  shift_in      = '0;
                  bit_index_in  = '0;
                  ack_choice_in = item.send_ack;
                  phase_in      = PH_R1;
               end
               i2cm_pkg::MODE_WAIT_ACK: begin
                  sda_dir_in = 1'b0; scl_in = 1'b1; poll_count_in = '0; phase_in = PH_K1;
               end
               default: begin
                  // unknown command: stay idle
               end
            endcase
         end
      end else if (unit_next >= {1'b0, cfg.unit_ticks}) begin
         // end of unit: take the next pin step
         unit_count_in = '0;
         case (phase_ff)
            PH_S1:  begin sda_in = 1'b0; phase_in = PH_S2; end
            PH_S2:  begin scl_in = 1'b0; finish = 1'b1; end
            PH_P1:  begin scl_in = 1'b1; phase_in = PH_P2; end
            PH_P2:  begin sda_in = 1'b1; finish = 1'b1; end
            PH_W1:  begin scl_in = 1'b1; phase_in = PH_W2A; end
            PH_W2A: phase_in = PH_W2B;
            PH_W2B: begin scl_in = 1'b0; phase_in = PH_W3; end
            PH_W3: begin
               shift_in = {shift_ff[6:0], 1'b0};
               if (bit_index_ff == 3'd7) begin
                  finish = 1'b1;
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
                  sda_in       = shift_ff[6];
                  phase_in     = PH_W1;
               end
            end
            PH_R1: begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], item.sda_in};
               phase_in = PH_R2A;
            end
            PH_R2A: phase_in = PH_R2B;
            PH_R2B: begin
               scl_in = 1'b0;
               if (bit_index_ff == 3'd7) begin
                  phase_in = PH_R3;
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
                  phase_in     = PH_R1;
               end
            end
            PH_R3: begin
               sda_dir_in = 1'b1;
               sda_in     = ~ack_choice_ff;
               phase_in   = PH_A1;
            end
            PH_A1:  begin scl_in = 1'b1; phase_in = PH_A2; end
            PH_A2:  begin scl_in = 1'b0; rd_byte_in = shift_ff; finish = 1'b1; end
            PH_K1, PH_KP: begin
               if (!item.sda_in) begin
                  scl_in      = 1'b0;
                  ack_flag_in = 1'b0;
                  finish      = 1'b1;
               end else if (poll_count_ff >= cfg.ack_poll_limit) begin
                  phase_in = PH_KL;
               end else begin
                  poll_count_in = poll_count_ff + 1'b1;
                  phase_in      = PH_KP;
               end
            end
            PH_KL: begin
               sda_dir_in = 1'b1; scl_in = 1'b0; sda_in = 1'b0; phase_in = PH_T1;
            end
            PH_T1:  begin scl_in = 1'b1; phase_in = PH_T2; end
            PH_T2: begin
               sda_in = 1'b1; scl_in = 1'b0; ack_flag_in = 1'b1; finish = 1'b1;
            end
            default: finish = 1'b1;
         endcase
         if (finish) begin
            phase_in = PH_IDLE;
            done_in  = 1'b1;
         end
      end else begin
         unit_count_in = unit_next[i2cm_pkg::UNIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         unit_count_ff <= '0;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         poll_count_ff <= '0;
         ack_flag_ff   <= 1'b0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         sda_dir_ff    <= 1'b0;
         rd_byte_ff    <= '0;
         ack_choice_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         unit_count_ff <= unit_count_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         poll_count_ff <= poll_count_in;
         ack_flag_ff   <= ack_flag_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         sda_dir_ff    <= sda_dir_in;
         rd_byte_ff    <= rd_byte_in;
         ack_choice_ff <= ack_choice_in;
         done_ff       <= done_in;
      end
   end

   assign result.scl_level     = scl_ff;
   assign result.sda_level     = sda_ff;
   assign result.sda_is_output = sda_dir_ff;
   assign result.busy_res      = (phase_ff != PH_IDLE);
   assign result.done_res      = done_ff;
   assign result.read_data     = rd_byte_ff;
   assign result.ack_timeout   = ack_flag_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> phase_ff == PH_IDLE)
      else $error("done raised while a command still runs");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> unit_count_ff == '0)
      else $error("unit counter not cleared in idle");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(phase_ff) && $stable(done_ff) && $stable(rd_byte_ff))
      else $error("sequencer moved without a step");

   a_timeout_release: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_T2 && unit_next >= {1'b0, cfg.unit_ticks}
      |=> ack_flag_ff && sda_ff && sda_dir_ff && !scl_ff)
      else $error("timeout stop left bus in wrong state");

endmodule

// ===== rtl/i2c_bit_level_master_core.sv =====
// Top level of the bit-level I2C master: input stage, sequencer and csr block.
//
// Each req item is one bus tick carrying an optional command and the sampled
// SDA level; each accepted item yields exactly one rsp item that shows the pin
// levels and status after that tick. One item is accepted per cycle while req_ready
// is high. rsp_valid rises after req acceptance once the item has been captured
// in an input register and the sequencer registers, which also form the rsp
// register, have advanced on it; a stalled rsp can delay that advance. A
// stalled rsp holds the input register, and req_ready drops only while both
// registers are full. Waveform steps last csr unit_ticks items each; a
// wait-for-ACK times out after ack_poll_limit extra polls, then sends a stop.
// Configuration writes are taken every cycle and should be made while idle.
module i2c_bit_level_master_core #(
   parameter logic [i2cm_pkg::UNIT_W-1:0] UnitTicksRst    = i2cm_pkg::UNIT_TICKS_RST,
   parameter logic [i2cm_pkg::POLL_W-1:0] AckPollLimitRst = i2cm_pkg::ACK_POLL_LIMIT_RST
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd_valid,
   input  logic [2:0]                       req_mode,
   input  logic [7:0]                       req_write_data,
   input  logic                             req_send_ack,
   input  logic                             req_sda_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_scl_level,
   output logic                             rsp_sda_level,
   output logic                             rsp_sda_is_output,
   output logic                             rsp_busy_res,
   output logic                             rsp_done_res,
   output logic [7:0]                       rsp_read_data,
   output logic                             rsp_ack_timeout,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [i2cm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0]  csr_data
);

   i2cm_pkg::cfg_type    cfg;
   i2cm_pkg::item_type   item_ff, item_in;
   i2cm_pkg::result_type result;
   logic                 in_valid_ff, in_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 step_en;
   logic                 req_take;

   // result slot frees when empty or being taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.cmd_valid  = req_cmd_valid;
         item_in.mode       = req_mode;
         item_in.write_data = req_write_data;
         item_in.send_ack   = req_send_ack;
         item_in.sda_in     = req_sda_in;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   i2cm_csr #(
      .UnitTicksRst    (UnitTicksRst),
      .AckPollLimitRst (AckPollLimitRst)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2cm_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scl_level     = result.scl_level;
   assign rsp_sda_level     = result.sda_level;
   assign rsp_sda_is_output = result.sda_is_output;
   assign rsp_busy_res      = result.busy_res;
   assign rsp_done_res      = result.done_res;
   assign rsp_read_data     = result.read_data;
   assign rsp_ack_timeout   = result.ack_timeout;

endmodule
